@@ hdl/fkc_pkg.sv @@
// Package for the flow key cache: payload structs, command codes, sizes.
// No dependencies.
package fkc_pkg;
	localparam int Capacity = 64;
	localparam int IdxW = $clog2(Capacity);
	localparam int KeyW = 144;

	localparam logic [1:0] MODE_LOOKUP = 2'd0;
	localparam logic [1:0] MODE_ADD    = 2'd1;
	localparam logic [1:0] MODE_TICK   = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [63:0] addr_high;
		logic [63:0] addr_low;
		logic [15:0] dest_port;
	} req_t;

	typedef struct packed {
		logic hit;
		logic dropped;
		logic swept;
	} rsp_t;

	// classified request handed from the front part to the back part
	typedef struct packed {
		logic [1:0]      mode;
		logic            found;
		logic [IdxW-1:0] slot;
		logic            has_free;
		logic [IdxW-1:0] free_slot;
		logic [KeyW-1:0] key;
	} cmd_t;
endpackage

@@ hdl/fkc_front.sv @@
// Front part: registers the request, then matches its key against all slots.
// Depends on fkc_pkg.
module fkc_front import fkc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  req_t                in_data,
	input  logic [Capacity-1:0] valid_vec,
	input  logic [KeyW-1:0]     keys [Capacity],
	input  logic                busy,
	output logic                cmd_valid,
	output cmd_t                cmd
);
	logic req_v_s1;
	req_t req_s1;

	// one request in flight at a time; back part reports busy until done
	assign in_stall = req_v_s1 | busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_v_s1 <= 1'b0;
		end else begin
			req_v_s1 <= in_valid & ~in_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid & ~in_stall) begin
			req_s1 <= in_data;
		end
	end

	logic [Capacity-1:0] match;
	logic [KeyW-1:0] key;
	assign key = {req_s1.addr_high, req_s1.addr_low, req_s1.dest_port};

	always_comb begin
		for (int i = 0; i < Capacity; i++) begin
			match[i] = valid_vec[i] && keys[i] == key;
		end
	end

	always_comb begin
		cmd = '0;
		cmd.mode = req_s1.mode;
		cmd.key = key;
		for (int i = Capacity - 1; i >= 0; i--) begin
			if (match[i]) begin
				cmd.found = 1'b1;
				cmd.slot = IdxW'(i);
			end
			if (!valid_vec[i]) begin
				cmd.has_free = 1'b1;
				cmd.free_slot = IdxW'(i);
			end
		end
	end
	assign cmd_valid = req_v_s1;
endmodule

@@ hdl/fkc_back.sv @@
// Back part: queue of classified requests, table update, tick and sweep.
// Depends on fkc_pkg.
module fkc_back import fkc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_data,
	input  logic                cmd_valid,
	input  cmd_t                cmd,
	output logic                busy,
	output logic [Capacity-1:0] valid_vec,
	output logic [KeyW-1:0]     keys [Capacity],
	output logic                out_valid,
	input  logic                out_stall,
	output rsp_t                out_data
);
	logic [15:0] limit_q;
	logic [31:0] now_q;
	logic [15:0] ticks_q;
	logic [Capacity-1:0] valid_q;
	logic [KeyW-1:0] key_q [Capacity];
	logic [31:0] stamp_q [Capacity];
	logic cmd_v_q;
	cmd_t cmd_q;
	logic [15:0] eff_lim;
	logic [15:0] ticks_inc;
	logic [Capacity-1:0] stale;

	assign valid_vec = valid_q;
	assign keys = key_q;
	assign eff_lim = (limit_q == 16'd0) ? 16'd1 : limit_q;
	assign ticks_inc = ticks_q + 16'd1;
	// hold the front while the queue or output holds a request
	assign busy = cmd_v_q | out_valid;

	always_comb begin
		for (int i = 0; i < Capacity; i++) begin
			stale[i] = (now_q + 32'd1 - stamp_q[i]) > {16'd0, eff_lim};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 16'd1;
			now_q <= '0;
			ticks_q <= '0;
			valid_q <= '0;
			cmd_v_q <= 1'b0;
			out_valid <= 1'b0;
			out_data <= '0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			if (cmd_valid) begin
				cmd_v_q <= 1'b1;
			end
			if (cmd_v_q && !out_valid) begin
				cmd_v_q <= 1'b0;
				out_valid <= 1'b1;
				out_data <= '0;
				case (cmd_q.mode)
					MODE_LOOKUP: begin
						out_data.hit <= cmd_q.found;
					end
					MODE_ADD: begin
						if (!cmd_q.found) begin
							if (cmd_q.has_free) begin
								valid_q[cmd_q.free_slot] <= 1'b1;
							end else begin
								out_data.dropped <= 1'b1;
							end
						end
					end
					MODE_TICK: begin
						now_q <= now_q + 32'd1;
						if (ticks_inc >= eff_lim) begin
							ticks_q <= '0;
							valid_q <= valid_q & ~stale;
							out_data.swept <= 1'b1;
						end else begin
							ticks_q <= ticks_inc;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid) begin
			cmd_q <= cmd;
		end
		if (cmd_v_q && !out_valid) begin
			if ((cmd_q.mode == MODE_LOOKUP || cmd_q.mode == MODE_ADD) && cmd_q.found) begin
				stamp_q[cmd_q.slot] <= now_q;
			end else if (cmd_q.mode == MODE_ADD && cmd_q.has_free) begin
				stamp_q[cmd_q.free_slot] <= now_q;
				key_q[cmd_q.free_slot] <= cmd_q.key;
			end
		end
	end
endmodule

@@ hdl/flow_key_cache_with_aging.sv @@
// Top level of the flow key cache with idle aging.
// Depends on fkc_pkg, fkc_front and fkc_back.
// The accepting edge registers the request. The key comparison against all 64 slots, done in
// parallel, is then registered into the one-entry queue. From the queue the table is updated
// and the result is registered. The next request is taken in the cycle after the result leaves,
// so a new request is not taken before the last result has left, and a stalled output holds it
// off. A sweep clears every stale slot in the same cycle as the table update and the result.
// The table is empty after reset, so no clearing pass is needed.
module flow_key_cache_with_aging import fkc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  req_t        in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output rsp_t        out_data
);
	logic busy;
	logic cmd_valid;
	cmd_t cmd;
	logic [Capacity-1:0] valid_vec;
	logic [KeyW-1:0] keys [Capacity];

	fkc_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.valid_vec, .keys, .busy, .cmd_valid, .cmd
	);

	fkc_back u_back (
		.clk, .arst_n, .cfg_we, .cfg_data, .cmd_valid, .cmd, .busy,
		.valid_vec, .keys, .out_valid, .out_stall, .out_data
	);
endmodule

@@ hdl/fkc_checker.sv @@
// Port checker for the flow key cache, bound to the top level.
// Depends on fkc_pkg.
module fkc_checker import fkc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input rsp_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0(out_data))
		else $error("more than one result flag set");
	a_accept_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request taken while one is in flight");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("request taken while a result waits");
endmodule

bind flow_key_cache_with_aging fkc_checker u_fkc_checker (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);
